### hw/rtl/srdz_pkg.sv
// Shared constants and types for the stick radial dead zone block.
// Depends on nothing; imported by stick_radial_dead_zone.

package srdz_pkg;

   localparam int SAMPLE_BITS_DEF      = 17;
   localparam int LENGTH_FRAC_BITS_DEF = 8;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   localparam int OUT_W  = 16;
   localparam int FRAC_W = 14;
   localparam int F_W    = FRAC_W + 1;
   localparam logic [F_W-1:0] ONE_Q14 = F_W'(1) << FRAC_W;

   localparam logic [CSR_DATA_W-1:0] DEAD_ZONE_RESET  = 16'd8000;
   localparam logic [CSR_DATA_W-1:0] FULL_SCALE_RESET = 16'd30000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEAD_ZONE  = 1'b0,
      CSR_FULL_SCALE = 1'b1
   } csr_index_type;

endpackage

### hw/rtl/stick_radial_dead_zone.sv
// Radial dead zone and Q2.14 scaling of one two-axis stick request per cycle while no response waits.
// Depends on srdz_pkg for constants, register indexes and reset values.
//
//   channel | handshake            | payload
//   req     | req_valid/req_ready  | req_stick_x, req_stick_y
//   rsp     | rsp_valid/rsp_ready  | rsp_out_x, rsp_out_y, rsp_in_dead_zone, rsp_at_full_scale
//   csr     | csr_write_en         | csr_index, csr_wdata
//
// One request enters per cycle while no response is waiting; the pipeline runs through
// the bit-per-stage square root and the two dividers.
// Reset clears the stage valid bits and loads the register reset values.
// A waiting response freezes every stage; nothing is dropped or repeated.

module stick_radial_dead_zone #(
   parameter int SAMPLE_BITS      = srdz_pkg::SAMPLE_BITS_DEF,
   parameter int LENGTH_FRAC_BITS = srdz_pkg::LENGTH_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_stick_x,
   input  logic signed [SAMPLE_BITS-1:0]       req_stick_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [srdz_pkg::OUT_W-1:0]   rsp_out_x,
   output logic signed [srdz_pkg::OUT_W-1:0]   rsp_out_y,
   output logic                                rsp_in_dead_zone,
   output logic                                rsp_at_full_scale,
   input  logic                                csr_write_en,
   input  logic [srdz_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [srdz_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import srdz_pkg::*;

   localparam int MAG_W  = SAMPLE_BITS;
   localparam int SQ_W   = 2 * SAMPLE_BITS + 2 * LENGTH_FRAC_BITS;
   localparam int TRY_W  = SQ_W + 1;
   localparam int LEN_W  = SAMPLE_BITS + LENGTH_FRAC_BITS;
   localparam int REF_W  = CSR_DATA_W + LENGTH_FRAC_BITS;
   localparam int CMP_W  = (LEN_W > REF_W) ? LEN_W : REF_W;
   localparam int Q_W    = F_W;
   localparam int PRD_W  = MAG_W + F_W;
   localparam int NUM_W  = PRD_W + LENGTH_FRAC_BITS;
   localparam int NSTAGE = LEN_W + FRAC_W + Q_W + 7;

   typedef struct packed {
      logic             sx;
      logic             sy;
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] ay;
      logic [LEN_W-1:0] len;
      logic             dead;
      logic             full;
   } side_type;

   logic [CSR_DATA_W-1:0] dead_zone_ff;
   logic [CSR_DATA_W-1:0] full_scale_ff;
   logic [NSTAGE-1:0]     pipe_vld_ff;
   logic                  adv;

   side_type              a_side_ff;
   side_type              a_side_in;
   side_type              b_side_ff;
   logic [2*MAG_W-1:0]    b_sqx_ff;
   logic [2*MAG_W-1:0]    b_sqy_ff;

   logic [SQ_W-1:0]       sq_rem_ff  [LEN_W+1];
   logic [LEN_W-1:0]      sq_root_ff [LEN_W+1];
   side_type              sq_side_ff [LEN_W+1];
   logic [SQ_W-1:0]       sq_rem_in  [LEN_W];
   logic [LEN_W-1:0]      sq_root_in [LEN_W];
   logic [TRY_W-1:0]      sq_trial;
   logic [TRY_W-1:0]      sq_rem_ext;

   side_type              d_side_ff;
   logic [CMP_W-1:0]      d_diff_ff;
   logic [CMP_W-1:0]      d_den_ff;
   logic                  d_fs_le_ff;
   logic [CMP_W-1:0]      dz_ext;
   logic [CMP_W-1:0]      fs_ext;
   logic [CMP_W-1:0]      len_ext;
   side_type              d_side_in;

   logic [CMP_W-1:0]      fd_rem_ff  [FRAC_W+1];
   logic [FRAC_W-1:0]     fd_q_ff    [FRAC_W+1];
   logic [CMP_W-1:0]      fd_den_ff  [FRAC_W+1];
   side_type              fd_side_ff [FRAC_W+1];
   logic [CMP_W-1:0]      fd_rem_in  [FRAC_W];
   logic [FRAC_W-1:0]     fd_q_in    [FRAC_W];
   logic [CMP_W:0]        fd_dbl;
   side_type              e_side_in;

   logic [F_W-1:0]        g_f;
   logic [PRD_W-1:0]      g_px;
   logic [PRD_W-1:0]      g_py;

   logic [NUM_W-1:0]      od_rx_ff   [Q_W+1];
   logic [NUM_W-1:0]      od_ry_ff   [Q_W+1];
   logic [Q_W-1:0]        od_qx_ff   [Q_W+1];
   logic [Q_W-1:0]        od_qy_ff   [Q_W+1];
   side_type              od_side_ff [Q_W+1];
   logic [NUM_W-1:0]      od_rx_in   [Q_W];
   logic [NUM_W-1:0]      od_ry_in   [Q_W];
   logic [Q_W-1:0]        od_qx_in   [Q_W];
   logic [Q_W-1:0]        od_qy_in   [Q_W];
   logic [NUM_W-1:0]      od_trial;

   side_type              r_side;
   logic                  r_zero;
   logic [OUT_W-1:0]      r_qx;
   logic [OUT_W-1:0]      r_qy;

   assign adv       = !pipe_vld_ff[NSTAGE-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = pipe_vld_ff[NSTAGE-1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff  <= DEAD_ZONE_RESET;
         full_scale_ff <= FULL_SCALE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEAD_ZONE:  dead_zone_ff  <= csr_wdata;
            CSR_FULL_SCALE: full_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff <= '0;
      end else if (adv) begin
         pipe_vld_ff <= {pipe_vld_ff[NSTAGE-2:0], req_valid};
      end
   end

   // magnitudes and signs
   always_comb begin
      a_side_in      = '0;
      a_side_in.sx   = req_stick_x[SAMPLE_BITS-1];
      a_side_in.sy   = req_stick_y[SAMPLE_BITS-1];
      a_side_in.ax   = req_stick_x[SAMPLE_BITS-1] ? (~req_stick_x + 1'b1) : req_stick_x;
      a_side_in.ay   = req_stick_y[SAMPLE_BITS-1] ? (~req_stick_y + 1'b1) : req_stick_y;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff     <= a_side_in;
         b_side_ff     <= a_side_ff;
         b_sqx_ff      <= a_side_ff.ax * a_side_ff.ax;
         b_sqy_ff      <= a_side_ff.ay * a_side_ff.ay;
         sq_rem_ff[0]  <= (SQ_W'(b_sqx_ff) + SQ_W'(b_sqy_ff)) << (2 * LENGTH_FRAC_BITS);
         sq_root_ff[0] <= '0;
         sq_side_ff[0] <= b_side_ff;
      end
   end

   // square root, one result bit per stage
   always_comb begin
      sq_trial   = '0;
      sq_rem_ext = '0;
      for (int k = 0; k < LEN_W; k++) begin
         sq_trial   = (TRY_W'(sq_root_ff[k]) << (LEN_W - k))
                    | (TRY_W'(1) << (2 * (LEN_W - 1 - k)));
         sq_rem_ext = TRY_W'(sq_rem_ff[k]);
         if (sq_rem_ext >= sq_trial) begin
            sq_rem_in[k]  = SQ_W'(sq_rem_ext - sq_trial);
            sq_root_in[k] = sq_root_ff[k] | (LEN_W'(1) << (LEN_W - 1 - k));
         end else begin
            sq_rem_in[k]  = sq_rem_ff[k];
            sq_root_in[k] = sq_root_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < LEN_W; k++) begin
            sq_rem_ff[k+1]  <= sq_rem_in[k];
            sq_root_ff[k+1] <= sq_root_in[k];
            sq_side_ff[k+1] <= sq_side_ff[k];
         end
      end
   end

   // dead zone test and scale factor operands
   always_comb begin
      dz_ext         = CMP_W'(dead_zone_ff) << LENGTH_FRAC_BITS;
      fs_ext         = CMP_W'(full_scale_ff) << LENGTH_FRAC_BITS;
      len_ext        = CMP_W'(sq_root_ff[LEN_W]);
      d_side_in      = sq_side_ff[LEN_W];
      d_side_in.len  = sq_root_ff[LEN_W];
      d_side_in.dead = len_ext < dz_ext;
      e_side_in      = d_side_ff;
      e_side_in.full = d_fs_le_ff || (d_diff_ff >= d_den_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_side_ff     <= d_side_in;
         d_diff_ff     <= len_ext - dz_ext;
         d_den_ff      <= fs_ext - dz_ext;
         d_fs_le_ff    <= fs_ext <= dz_ext;
         fd_side_ff[0] <= e_side_in;
         fd_rem_ff[0]  <= d_diff_ff;
         fd_den_ff[0]  <= d_den_ff;
         fd_q_ff[0]    <= '0;
      end
   end

   // scale factor divider, one quotient bit per stage
   always_comb begin
      fd_dbl = '0;
      for (int k = 0; k < FRAC_W; k++) begin
         fd_dbl = {fd_rem_ff[k], 1'b0};
         if (fd_dbl >= {1'b0, fd_den_ff[k]}) begin
            fd_rem_in[k] = CMP_W'(fd_dbl - {1'b0, fd_den_ff[k]});
            fd_q_in[k]   = {fd_q_ff[k][FRAC_W-2:0], 1'b1};
         end else begin
            fd_rem_in[k] = CMP_W'(fd_dbl);
            fd_q_in[k]   = {fd_q_ff[k][FRAC_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < FRAC_W; k++) begin
            fd_rem_ff[k+1]  <= fd_rem_in[k];
            fd_q_ff[k+1]    <= fd_q_in[k];
            fd_den_ff[k+1]  <= fd_den_ff[k];
            fd_side_ff[k+1] <= fd_side_ff[k];
         end
      end
   end

   // component times scale factor
   always_comb begin
      g_f  = fd_side_ff[FRAC_W].full ? ONE_Q14 : {1'b0, fd_q_ff[FRAC_W]};
      g_px = fd_side_ff[FRAC_W].ax * g_f;
      g_py = fd_side_ff[FRAC_W].ay * g_f;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         od_rx_ff[0]   <= NUM_W'(g_px) << LENGTH_FRAC_BITS;
         od_ry_ff[0]   <= NUM_W'(g_py) << LENGTH_FRAC_BITS;
         od_qx_ff[0]   <= '0;
         od_qy_ff[0]   <= '0;
         od_side_ff[0] <= fd_side_ff[FRAC_W];
      end
   end

   // divide by length, one quotient bit per stage for each axis
   always_comb begin
      od_trial = '0;
      for (int k = 0; k < Q_W; k++) begin
         od_trial = NUM_W'(od_side_ff[k].len) << (Q_W - 1 - k);
         if (od_rx_ff[k] >= od_trial) begin
            od_rx_in[k] = od_rx_ff[k] - od_trial;
            od_qx_in[k] = od_qx_ff[k] | (Q_W'(1) << (Q_W - 1 - k));
         end else begin
            od_rx_in[k] = od_rx_ff[k];
            od_qx_in[k] = od_qx_ff[k];
         end
         if (od_ry_ff[k] >= od_trial) begin
            od_ry_in[k] = od_ry_ff[k] - od_trial;
            od_qy_in[k] = od_qy_ff[k] | (Q_W'(1) << (Q_W - 1 - k));
         end else begin
            od_ry_in[k] = od_ry_ff[k];
            od_qy_in[k] = od_qy_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < Q_W; k++) begin
            od_rx_ff[k+1]   <= od_rx_in[k];
            od_ry_ff[k+1]   <= od_ry_in[k];
            od_qx_ff[k+1]   <= od_qx_in[k];
            od_qy_ff[k+1]   <= od_qy_in[k];
            od_side_ff[k+1] <= od_side_ff[k];
         end
      end
   end

   // sign and response register
   always_comb begin
      r_side = od_side_ff[Q_W];
      r_zero = r_side.dead || (r_side.len == '0);
      r_qx   = OUT_W'(od_qx_ff[Q_W]);
      r_qy   = OUT_W'(od_qy_ff[Q_W]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_out_x         <= r_zero ? '0 : (r_side.sx ? (~r_qx + 1'b1) : r_qx);
         rsp_out_y         <= r_zero ? '0 : (r_side.sy ? (~r_qy + 1'b1) : r_qy);
         rsp_in_dead_zone  <= r_side.dead;
         rsp_at_full_scale <= !r_side.dead && r_side.full;
      end
   end

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_x <= 16'sd16384) && (rsp_out_x >= -16'sd16384)
                 && (rsp_out_y <= 16'sd16384) && (rsp_out_y >= -16'sd16384))
      else $error("response component beyond unit scale");

   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_dead_zone |->
         rsp_out_x == '0 && rsp_out_y == '0 && !rsp_at_full_scale)
      else $error("dead zone response not centered");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a waiting response");

   a_full_mag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_x == 16'sd16384 || rsp_out_x == -16'sd16384) |->
         rsp_at_full_scale)
      else $error("unit magnitude without saturated factor");

endmodule
